// File: rtl/nearest_centroid_label_transfer_assert.svh
// Assertion helpers; each expects clk and rst in scope.
`ifndef NEAREST_CENTROID_LABEL_TRANSFER_ASSERT_SVH
`define NEAREST_CENTROID_LABEL_TRANSFER_ASSERT_SVH

// Consequent must hold in the same cycle.
`define NCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the next cycle.
`define NCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ncl_pkg.sv
`timescale 1ns / 1ps
package ncl_pkg;

  localparam int MAX_REF_POINTS = 4096;
  localparam int COORD_BITS     = 24;
  localparam int ADDR_W         = $clog2(MAX_REF_POINTS);
  localparam int CNT_W          = $clog2(MAX_REF_POINTS + 1);
  localparam int LABEL_W        = 10;
  localparam int LMAX_W         = LABEL_W + 1;
  localparam int SQ_W           = 2 * COORD_BITS;
  localparam int DIST_W         = SQ_W + 2;
  localparam int PARTS_W        = 11;
  localparam int TOTAL_W        = 12;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = DIST_W;
  localparam int ENTRY_W        = 3 * COORD_BITS + LABEL_W;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_3D   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_3D     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_PARTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_PARTS  = 3'd4;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear;
    logic load;
    logic scan_step;
    logic out_load;
    logic out_report;
  } ncl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
  } ncl_status_t;

endpackage

// File: rtl/ncl_ctrl.sv
`timescale 1ns / 1ps
module ncl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ncl_pkg::OP_W-1:0]   opcode,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  ncl_pkg::ncl_status_t       status,
  output ncl_pkg::ncl_cmd_t          cmd
);
  import ncl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_QRES = 2'd2;
  localparam logic [1:0] S_RRES = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD:  cmd.load  = 1'b1;
            OP_QUERY: begin
              cmd.capture = 1'b1;
              state_next  = S_SCAN;
            end
            OP_REPORT: state_next = S_RRES;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!status.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (!status.pipe_busy) begin
          state_next = S_QRES;
        end
      end
      S_QRES, S_RRES: begin
        // hold the result until the output register frees up
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_report = (state == S_RRES);
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ncl_datapath.sv
`timescale 1ns / 1ps
module ncl_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [ncl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ncl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_z,
  input  logic [ncl_pkg::LABEL_W-1:0]           part_label,
  input  ncl_pkg::ncl_cmd_t                     cmd,
  output ncl_pkg::ncl_status_t                  status,
  output logic                                  result_kind,
  output logic [ncl_pkg::LABEL_W-1:0]           nearest_label,
  output logic                                  matched,
  output logic signed [ncl_pkg::TOTAL_W-1:0]    part_total
);
  import ncl_pkg::*;

  localparam logic signed [TOTAL_W-1:0] REQ_AUTO = -TOTAL_W'(1);
  localparam logic [DIST_W-1:0]         LIMIT_RESET = '1;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
  endfunction

  // configuration
  logic                       query_3d;
  logic                       ref_3d;
  logic [DIST_W-1:0]          limit_sq;
  logic [PARTS_W-1:0]         file_parts;
  logic signed [TOTAL_W-1:0]  req_parts;

  // table bookkeeping
  logic [CNT_W-1:0]   ref_count;
  logic [LMAX_W-1:0]  ref_label_max;
  logic [LMAX_W-1:0]  query_label_max;
  logic [CNT_W-1:0]   idx;
  logic [ENTRY_W-1:0] mem [MAX_REF_POINTS];
  logic [ENTRY_W-1:0] rd_entry;
  logic               load_ok;
  logic [LMAX_W-1:0]  load_inc;

  // query and pipeline
  logic [COORD_BITS-1:0] qx, qy, qz;
  logic                  v0, v1, v2, v3;
  logic [COORD_BITS-1:0] mx, my, mz;
  logic [LABEL_W-1:0]    l1, l2, l3;
  logic [SQ_W-1:0]       sx, sy, sz;
  logic [DIST_W-1:0]     dist_sum;
  logic [DIST_W-1:0]     best;
  logic [LABEL_W-1:0]    best_label;
  logic                  hit;
  logic [LMAX_W-1:0]     best_inc;

  // entry slices
  logic [COORD_BITS-1:0] ex, ey, ez, ez_used;
  logic [LABEL_W-1:0]    elab;

  // report
  logic [PARTS_W-1:0]        calc;
  logic signed [TOTAL_W-1:0] calc_s;
  logic signed [TOTAL_W-1:0] total;

  assign load_ok  = (ref_count < CNT_W'(MAX_REF_POINTS));
  assign load_inc = LMAX_W'(part_label) + LMAX_W'(1);
  assign best_inc = LMAX_W'(best_label) + LMAX_W'(1);

  assign ex      = rd_entry[ENTRY_W-1 -: COORD_BITS];
  assign ey      = rd_entry[ENTRY_W-1-COORD_BITS -: COORD_BITS];
  assign ez      = rd_entry[LABEL_W +: COORD_BITS];
  assign elab    = rd_entry[LABEL_W-1:0];
  assign ez_used = ref_3d ? ez : '0;

  assign status.scan_done = (idx == ref_count);
  assign status.pipe_busy = v0 | v1 | v2 | v3;

  always_comb begin
    calc   = (PARTS_W'(ref_label_max) > file_parts) ? PARTS_W'(ref_label_max) : file_parts;
    calc_s = $signed({1'b0, calc});
    total  = req_parts;
    if ((LMAX_W'(query_label_max) < LMAX_W'(calc)) && (req_parts == REQ_AUTO)) begin
      total = calc_s;
    end
    if (calc_s < total) begin
      total = calc_s;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[ref_count[ADDR_W-1:0]] <= {coord_x, coord_y, coord_z, part_label};
    end
    if (cmd.scan_step) begin
      rd_entry <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_3d        <= 1'b1;
      ref_3d          <= 1'b1;
      limit_sq        <= LIMIT_RESET;
      file_parts      <= '0;
      req_parts       <= REQ_AUTO;
      ref_count       <= '0;
      ref_label_max   <= '0;
      query_label_max <= '0;
      idx             <= '0;
      v0              <= 1'b0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_QUERY_3D:   query_3d   <= cfg_data[0];
          CFG_REF_3D:     ref_3d     <= cfg_data[0];
          CFG_LIMIT_SQ:   limit_sq   <= cfg_data[DIST_W-1:0];
          CFG_FILE_PARTS: file_parts <= cfg_data[PARTS_W-1:0];
          CFG_REQ_PARTS:  req_parts  <= $signed(cfg_data[TOTAL_W-1:0]);
          default: ;
        endcase
      end
      if (cmd.clear) begin
        ref_count       <= '0;
        ref_label_max   <= '0;
        query_label_max <= '0;
      end
      // drop loads once the table is full
      if (cmd.load && load_ok) begin
        ref_count <= ref_count + CNT_W'(1);
        if (load_inc > ref_label_max) begin
          ref_label_max <= load_inc;
        end
      end
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + CNT_W'(1);
      end
      v0 <= cmd.scan_step;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (cmd.out_load && !cmd.out_report && (best_inc > query_label_max)) begin
        query_label_max <= best_inc;
      end
    end
  end

  // distance pipeline: difference, square, sum, compare
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx         <= coord_x;
      qy         <= coord_y;
      qz         <= query_3d ? coord_z : '0;
      best       <= limit_sq;
      best_label <= '0;
      hit        <= 1'b0;
    end else if (v3 && (dist_sum < best)) begin
      best       <= dist_sum;
      best_label <= l3;
      hit        <= 1'b1;
    end
    mx       <= abs_diff(ex, qx);
    my       <= abs_diff(ey, qy);
    mz       <= abs_diff(ez_used, qz);
    l1       <= elab;
    sx       <= mx * mx;
    sy       <= my * my;
    sz       <= mz * mz;
    l2       <= l1;
    dist_sum <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    l3       <= l2;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_report) begin
        result_kind   <= KIND_REPORT;
        nearest_label <= '0;
        matched       <= 1'b0;
        part_total    <= total;
      end else begin
        result_kind   <= KIND_QUERY;
        nearest_label <= best_label;
        matched       <= hit;
        part_total    <= '0;
      end
    end
  end

endmodule

// File: rtl/nearest_centroid_label_transfer.sv
`timescale 1ns / 1ps
// Clear and load words are acted on as they are accepted; a report word passes through a
// report state into the output register. A query walks the loaded table one entry per cycle
// through a four-stage distance pipeline; once the scan ends and the pipeline drains, the
// answer waits in a result state until the output register is free. No new word is taken
// until that answer or report is loaded, so a stalled output word also holds back the input.
// Synchronous active-high reset empties the table and loads default configuration.
`include "nearest_centroid_label_transfer_assert.svh"
module nearest_centroid_label_transfer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ncl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ncl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ncl_pkg::OP_W-1:0]              opcode,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [ncl_pkg::COORD_BITS-1:0] coord_z,
  input  logic [ncl_pkg::LABEL_W-1:0]           part_label,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  result_kind,
  output logic [ncl_pkg::LABEL_W-1:0]           nearest_label,
  output logic                                  matched,
  output logic signed [ncl_pkg::TOTAL_W-1:0]    part_total
);
  import ncl_pkg::*;

  ncl_cmd_t    cmd;
  ncl_status_t status;

  assign cfg_ready = 1'b1;

  ncl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ncl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .part_label    (part_label),
    .cmd           (cmd),
    .status        (status),
    .result_kind   (result_kind),
    .nearest_label (nearest_label),
    .matched       (matched),
    .part_total    (part_total)
  );

  `NCL_ASSERT_SAME(a_no_overread, cmd.scan_step, !status.scan_done, "table read past count")
  `NCL_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "pending word lost")
  `NCL_ASSERT_SAME(a_drained, cmd.out_load && !cmd.out_report, !status.pipe_busy,
                   "answer before pipeline drained")
  `NCL_ASSERT_NEXT(a_query_busy, in_valid && in_ready && opcode == OP_QUERY, !in_ready,
                   "word taken during scan")

endmodule
